FILE: sv/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, widths and codes for the frustum cull classifier.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int COORD_W        = 16;
  localparam int NUM_PLANES     = 6;
  localparam int PLANE_COUNT_DEF = 6;
  localparam int PLANE_W        = 64;
  localparam int MARGIN_W       = 20;
  localparam int FRAC_BITS      = 14;
  localparam int PROD_W         = 32;
  localparam int OFF_W          = 32;
  localparam int SUM_W          = 34;

  localparam int CFG_IDX_W      = 4;
  localparam int PLANE_IDX_W    = $clog2(NUM_PLANES);

  localparam logic [CFG_IDX_W-1:0] REG_POINT_MARGIN = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN   = CFG_IDX_W'(7);

  localparam logic [MARGIN_W-1:0] POINT_MARGIN_RST = MARGIN_W'(164);
  localparam logic [MARGIN_W-1:0] BOX_MARGIN_RST   = MARGIN_W'(0);

  localparam int IN_DATA_W      = 6 * COORD_W;
  localparam int VERDICT_W      = 2;
  localparam int OUT_DATA_W     = 8;

  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SPANNING = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec3_t;

  // d in the top bits, nx in the low bits
  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic fail_pos;
    logic fail_neg;
  } lane_fail_t;

endpackage

FILE: sv/frustum_cull_classifier_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_classifier_top
// Point and box classification against up to six configured frustum planes.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is taken; the input,
// product and output registers form a three-deep pipeline, and the input
// stalls only when every stage is full and the output is not taken.
// Reset: clears all pipeline valids, zeroes the planes and loads the default
// margins.
// ----------------------------------------------------------------------------
module frustum_cull_classifier_top #(
  parameter int PLANE_COUNT = cfc_pkg::PLANE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // verdict, zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfc_pkg::PLANE_W-1:0]       cfg_data
);
  import cfc_pkg::*;

  plane_t                 planes [NUM_PLANES];
  logic [MARGIN_W-1:0]    point_margin;
  logic [MARGIN_W-1:0]    box_margin;
  logic [MARGIN_W-1:0]    margin_sel;

  logic                   in_vld;
  logic                   in_mode;
  vec3_t                  in_lo;
  vec3_t                  in_hi;
  logic                   prod_vld;
  logic                   prod_mode;
  logic                   out_vld;
  logic                   out_mode;
  logic [VERDICT_W-1:0]   verdict;
  logic [VERDICT_W-1:0]   verdict_next;

  logic                   ready_out;
  logic                   ready_prod;
  logic                   ready_in;

  lane_fail_t             fails [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] fail_pos_vec;
  logic [PLANE_COUNT-1:0] fail_neg_vec;

  assign cfg_ready = 1'b1;

  cfc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .planes       (planes),
    .point_margin (point_margin),
    .box_margin   (box_margin)
  );

  assign ready_out     = !out_vld || m_axis_tready;
  assign ready_prod    = !prod_vld || ready_out;
  assign ready_in      = !in_vld || ready_prod;
  assign s_axis_tready = ready_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      prod_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      if (ready_in) begin
        in_vld <= s_axis_tvalid;
      end
      if (ready_prod) begin
        prod_vld <= in_vld;
      end
      if (ready_out) begin
        out_vld <= prod_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in) begin
      in_mode <= s_axis_tuser;
      in_lo.x <= s_axis_tdata[COORD_W*0 +: COORD_W];
      in_lo.y <= s_axis_tdata[COORD_W*1 +: COORD_W];
      in_lo.z <= s_axis_tdata[COORD_W*2 +: COORD_W];
      in_hi.x <= s_axis_tdata[COORD_W*3 +: COORD_W];
      in_hi.y <= s_axis_tdata[COORD_W*4 +: COORD_W];
      in_hi.z <= s_axis_tdata[COORD_W*5 +: COORD_W];
    end
    if (ready_prod) begin
      prod_mode <= in_mode;
    end
    if (ready_out) begin
      out_mode <= prod_mode;
      verdict  <= verdict_next;
    end
  end

  assign margin_sel = in_mode ? box_margin : point_margin;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    cfc_plane_lane u_lane (
      .clk    (clk),
      .en     (ready_prod),
      .box    (in_mode),
      .lo     (in_lo),
      .hi     (in_hi),
      .plane  (planes[p]),
      .margin (margin_sel),
      .fail   (fails[p])
    );
    assign fail_pos_vec[p] = fails[p].fail_pos;
    assign fail_neg_vec[p] = fails[p].fail_neg;
  end

  always_comb begin
    if (|fail_pos_vec) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (prod_mode && (|fail_neg_vec)) begin
      verdict_next = VERDICT_SPANNING;
    end else begin
      verdict_next = VERDICT_INSIDE;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {{(OUT_DATA_W-VERDICT_W){1'b0}}, verdict};

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_vld && prod_vld && out_vld))
    else $error("input stalled with a pipeline bubble");

  a_point_no_span: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_mode) |-> (verdict != VERDICT_SPANNING))
    else $error("point item classified as spanning");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_SPANNING ||
                 verdict == VERDICT_OUTSIDE))
    else $error("invalid verdict code");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (prod_vld && ready_out) |=> out_vld)
    else $error("product stage item lost");

endmodule

FILE: sv/cfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfc_cfg_regs
// Plane and margin registers written through the configuration channel.
// ----------------------------------------------------------------------------
module cfc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfc_pkg::PLANE_W-1:0]      cfg_data,
  output cfc_pkg::plane_t                  planes [cfc_pkg::NUM_PLANES],
  output logic [cfc_pkg::MARGIN_W-1:0]     point_margin,
  output logic [cfc_pkg::MARGIN_W-1:0]     box_margin
);
  import cfc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
      point_margin <= POINT_MARGIN_RST;
      box_margin   <= BOX_MARGIN_RST;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_W'(NUM_PLANES)) begin
        planes[cfg_index[PLANE_IDX_W-1:0]] <= plane_t'(cfg_data);
      end else if (cfg_index == REG_POINT_MARGIN) begin
        point_margin <= cfg_data[MARGIN_W-1:0];
      end else if (cfg_index == REG_BOX_MARGIN) begin
        box_margin <= cfg_data[MARGIN_W-1:0];
      end
    end
  end

endmodule

FILE: sv/cfc_plane_lane.sv
// ----------------------------------------------------------------------------
// cfc_plane_lane
// One plane: vertex pick and registered products, then sum and sign test.
// ----------------------------------------------------------------------------
module cfc_plane_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          box,
  input  cfc_pkg::vec3_t                lo,
  input  cfc_pkg::vec3_t                hi,
  input  cfc_pkg::plane_t               plane,
  input  logic [cfc_pkg::MARGIN_W-1:0]  margin,
  output cfc_pkg::lane_fail_t           fail
);
  import cfc_pkg::*;

  vec3_t va;
  vec3_t vb;
  logic signed [PROD_W-1:0] prod_pos [3];
  logic signed [PROD_W-1:0] prod_neg [3];
  logic signed [OFF_W-1:0]  off;
  logic signed [SUM_W-1:0]  sum_pos;
  logic signed [SUM_W-1:0]  sum_neg;

  // points use lo for the positive test; boxes use the positive and negative corners
  always_comb begin
    va.x = (box && !plane.nx[COORD_W-1]) ? hi.x : lo.x;
    va.y = (box && !plane.ny[COORD_W-1]) ? hi.y : lo.y;
    va.z = (box && !plane.nz[COORD_W-1]) ? hi.z : lo.z;
    vb.x = plane.nx[COORD_W-1] ? hi.x : lo.x;
    vb.y = plane.ny[COORD_W-1] ? hi.y : lo.y;
    vb.z = plane.nz[COORD_W-1] ? hi.z : lo.z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_pos[0] <= PROD_W'(plane.nx) * PROD_W'(va.x);
      prod_pos[1] <= PROD_W'(plane.ny) * PROD_W'(va.y);
      prod_pos[2] <= PROD_W'(plane.nz) * PROD_W'(va.z);
      prod_neg[0] <= PROD_W'(plane.nx) * PROD_W'(vb.x);
      prod_neg[1] <= PROD_W'(plane.ny) * PROD_W'(vb.y);
      prod_neg[2] <= PROD_W'(plane.nz) * PROD_W'(vb.z);
      off <= (OFF_W'(plane.d) <<< FRAC_BITS)
             + $signed({{(OFF_W-MARGIN_W){1'b0}}, margin});
    end
  end

  // s < -margin  <=>  s + margin < 0
  always_comb begin
    sum_pos = SUM_W'(prod_pos[0]) + SUM_W'(prod_pos[1]) + SUM_W'(prod_pos[2])
              + SUM_W'(off);
    sum_neg = SUM_W'(prod_neg[0]) + SUM_W'(prod_neg[1]) + SUM_W'(prod_neg[2])
              + SUM_W'(off);
    fail.fail_pos = sum_pos[SUM_W-1];
    fail.fail_neg = sum_neg[SUM_W-1];
  end

endmodule
